// ----- rtl/rfc_pkg.sv -----
// Radio frame checker package: channel payload types, command type, constants.
// No dependencies; used by every module of the block.
package rfc_pkg;

    localparam int FRAME_LEN = 8;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam int REPLY_LEN = 5;
    localparam int K_W       = $clog2(REPLY_LEN);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [K_W-1:0]   LAST_K   = K_W'(REPLY_LEN - 1);

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_RESYNC = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT = 2'd1;

    localparam logic [15:0] RX_TIMEOUT_RST = 16'd4000;
    localparam logic [7:0]  FAIL_LIMIT_RST = 8'd20;

    localparam logic [7:0] HDR_BYTE = 8'd253;
    localparam logic [7:0] TRL_BYTE = 8'd254;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       frame_done;
        logic       frame_ok;
    } t_out;

    typedef struct packed {
        logic            is_read;
        logic            ok;
        logic            good;
        logic [3:0][7:0] payload;
    } t_cmd;

    function automatic logic [7:0] fallback_byte(input logic [K_W-1:0] k);
        logic [7:0] v;
        unique case (k)
            3'd0:    v = 8'd127;
            3'd1:    v = 8'd128;
            3'd2:    v = 8'd111;
            3'd3:    v = 8'd111;
            3'd4:    v = 8'd5;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/rfc_front.sv -----
// Front end: accepts items, gathers frames, checks them, keeps the failsafe state
// and the configuration registers, and issues commands to the queue. Uses rfc_pkg.
module rfc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rfc_pkg::t_in                  i_in_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rfc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_q_full,
    output logic                          o_push,
    output rfc_pkg::t_cmd                 o_cmd
);

    logic [15:0]               r_timeout;
    logic [7:0]                r_limit;
    logic [7:0]                r_frame [rfc_pkg::FRAME_LEN];
    logic [rfc_pkg::POS_W-1:0] r_pos, n_pos;
    logic [3:0][7:0]           r_payload, n_payload;
    logic                      r_good, n_good;
    logic [7:0]                r_bad, n_bad;
    logic [15:0]               r_idle, n_idle;

    logic       accept;
    logic [9:0] sum;
    logic [8:0] chk;
    logic       ok;
    logic       good_upd;
    logic       fail;

    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    assign sum = 10'(r_frame[1]) + 10'(r_frame[2]) + 10'(r_frame[3]) + 10'(r_frame[4]);
    assign chk = 9'(sum[9:3]) + 9'(r_frame[4]);
    assign ok  = (r_frame[0] == rfc_pkg::HDR_BYTE) && (i_in_data.rx_byte == rfc_pkg::TRL_BYTE)
              && ({1'b0, r_frame[6]} == chk);

    always_comb begin
        n_pos     = r_pos;
        n_payload = r_payload;
        good_upd  = r_good;
        n_bad     = r_bad;
        n_idle    = r_idle;
        o_push    = 1'b0;
        o_cmd     = '0;
        unique case (i_in_data.kind)
            rfc_pkg::KIND_BYTE: begin
                if (r_pos == rfc_pkg::LAST_POS) begin
                    n_pos = '0;
                    if (ok) begin
                        n_payload = {r_frame[4], r_frame[3], r_frame[2], r_frame[1]};
                        good_upd  = 1'b1;
                        n_bad     = '0;
                    end else if (r_bad != 8'hFF) begin
                        n_bad = r_bad + 8'd1;
                    end
                    n_idle      = '0;
                    o_push      = accept;
                    o_cmd.ok    = ok;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            rfc_pkg::KIND_TICK: begin
                if (r_idle != 16'hFFFF) begin
                    n_idle = r_idle + 16'd1;
                end
            end
            rfc_pkg::KIND_READ: begin
                o_push        = accept;
                o_cmd.is_read = 1'b1;
            end
            rfc_pkg::KIND_RESYNC: begin
                n_pos = '0;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
        fail          = (n_idle >= r_timeout) || (n_bad >= r_limit);
        n_good        = good_upd && !fail;
        o_cmd.good    = n_good;
        o_cmd.payload = r_payload;
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in_data.kind == rfc_pkg::KIND_BYTE)) begin
            r_frame[r_pos] <= i_in_data.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= rfc_pkg::RX_TIMEOUT_RST;
            r_limit   <= rfc_pkg::FAIL_LIMIT_RST;
            r_pos     <= '0;
            r_payload <= '0;
            r_good    <= 1'b0;
            r_bad     <= '0;
            r_idle    <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == rfc_pkg::CFG_RX_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end else if (i_cfg_index == rfc_pkg::CFG_FAIL_LIMIT) begin
                    r_limit <= i_cfg_data[7:0];
                end
            end
            if (accept) begin
                r_pos     <= n_pos;
                r_payload <= n_payload;
                r_good    <= n_good;
                r_bad     <= n_bad;
                r_idle    <= n_idle;
            end
        end
    end

endmodule

// ----- rtl/rfc_queue.sv -----
// Command queue between front and back end; a small register FIFO.
// Uses rfc_pkg::t_cmd.
module rfc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rfc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rfc_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rfc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rfc_back.sv -----
// Back end: expands queued commands into result items through an output register.
// Uses rfc_pkg.
module rfc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  rfc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rfc_pkg::t_out o_out_data
);

    logic                    r_out_valid;
    rfc_pkg::t_out           r_out;
    rfc_pkg::t_out           n_out;
    logic [rfc_pkg::K_W-1:0] r_k;
    logic                    load;
    logic                    done;

    assign load = !r_out_valid || i_out_ready;

    always_comb begin
        n_out = '0;
        if (i_cmd.is_read) begin
            if (!i_cmd.good) begin
                n_out.out_byte = rfc_pkg::fallback_byte(r_k);
            end else if (r_k != rfc_pkg::LAST_K) begin
                n_out.out_byte = i_cmd.payload[r_k[1:0]];
            end
            n_out.last = (r_k == rfc_pkg::LAST_K);
        end else begin
            n_out.last       = 1'b1;
            n_out.frame_done = 1'b1;
            n_out.frame_ok   = i_cmd.ok;
        end
        done = n_out.last;
    end

    assign o_pop       = load && i_q_valid && done;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else if (load) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_k <= done ? '0 : r_k + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/radio_frame_checker_with_failsafe_unit.sv -----
// Top level of the radio frame checker with failsafe: front end, command queue,
// back end. Depends on rfc_pkg, rfc_front, rfc_queue, rfc_back.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (rfc_pkg::t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (rfc_pkg::t_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// The front end takes one item per cycle while the command queue has room.
// A completed frame emits one result and a read emits five, one per cycle from
// the output register while i_out_ready is high, so a run of reads is held
// back by the back end's single output port. Synchronous active-low reset; no
// clearing pass. Output stalls fill the queue and then drop o_in_ready.
module radio_frame_checker_with_failsafe_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rfc_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rfc_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rfc_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    rfc_pkg::t_cmd cmd_in;
    rfc_pkg::t_cmd cmd_out;

    rfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (cmd_in)
    );

    rfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (cmd_out)
    );

    rfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (cmd_out),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/rfc_checker.sv -----
// Port-level checks for the radio frame checker, bound to the top level.
// Depends on rfc_pkg and radio_frame_checker_with_failsafe_unit.
module rfc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input rfc_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output transfer dropped or changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |->
            o_out_data.last && (o_out_data.out_byte == 8'd0))
        else $error("frame status result malformed");

    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_ok |-> o_out_data.frame_done)
        else $error("frame_ok without frame_done");

endmodule

bind radio_frame_checker_with_failsafe_unit rfc_checker u_rfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
